// ===== hw/rtl/shac_pkg.sv =====
// ----------------------------------------------------------------------------
// shac_pkg
// Shared types and constants of the segment heap allocator.
// ----------------------------------------------------------------------------
package shac_pkg;

    localparam int HEAP_SIZE_DEF  = 1024;
    localparam int MAX_BLOCKS_DEF = 64;

    // Fixed field widths of the stream words.
    localparam int NAME_W   = 8;
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 3;
    localparam int BASE_W   = 10;
    localparam int LENGTH_W = 11;

    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_ZERO     = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        HOP_NONE,
        HOP_CARVE,
        HOP_JOIN,
        HOP_GROW_DOWN,
        HOP_GROW_UP,
        HOP_NEW
    } t_hole_op;

    typedef enum logic [1:0] {
        UOP_NONE,
        UOP_SET,
        UOP_CLEAR
    } t_used_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_USCAN,
        S_HSCAN,
        S_DONE
    } t_state;

    // Control handed to every hole cell.
    typedef struct packed {
        t_hole_op   op;
        logic [1:0] policy;
    } t_hole_ctl;

endpackage

// ===== hw/rtl/shac_hole_cell.sv =====
// ----------------------------------------------------------------------------
// shac_hole_cell
// One entry of the free hole table plus its stage of the hole search wave.
// ----------------------------------------------------------------------------
module shac_hole_cell import shac_pkg::*; #(
    parameter int LW        = 11,
    parameter int IW        = 6,
    parameter int CW        = 11,
    parameter int IDX       = 0,
    parameter int HEAP_SIZE = HEAP_SIZE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_hole_ctl     i_ctl,
    input  logic [CW-1:0] i_size,
    input  logic [LW-1:0] i_fbase,
    input  logic [LW-1:0] i_fend,
    input  logic [IW-1:0] i_idx_a,
    input  logic [IW-1:0] i_idx_b,
    input  logic [LW-1:0] i_base,
    input  logic [LW-1:0] i_len,
    input  logic          i_go,
    input  logic          i_pick_v,
    input  logic [IW-1:0] i_pick_i,
    input  logic [LW-1:0] i_pick_b,
    input  logic [LW-1:0] i_pick_l,
    input  logic          i_bef_v,
    input  logic [IW-1:0] i_bef_i,
    input  logic          i_aft_v,
    input  logic [IW-1:0] i_aft_i,
    input  logic [LW-1:0] i_aft_l,
    input  logic          i_slot_v,
    input  logic [IW-1:0] i_slot_i,
    output logic          o_go,
    output logic          o_pick_v,
    output logic [IW-1:0] o_pick_i,
    output logic [LW-1:0] o_pick_b,
    output logic [LW-1:0] o_pick_l,
    output logic          o_bef_v,
    output logic [IW-1:0] o_bef_i,
    output logic          o_aft_v,
    output logic [IW-1:0] o_aft_i,
    output logic [LW-1:0] o_aft_l,
    output logic          o_slot_v,
    output logic [IW-1:0] o_slot_i
);

    localparam logic [IW-1:0] ME = IW'(IDX);

    logic          r_valid;
    logic [LW-1:0] r_base;
    logic [LW-1:0] r_len;
    logic          r_go;
    logic          r_pick_v, r_bef_v, r_aft_v, r_slot_v;
    logic [IW-1:0] r_pick_i, r_bef_i, r_aft_i, r_slot_i;
    logic [LW-1:0] r_pick_b, r_pick_l, r_aft_l;

    logic          fits, lower, better, take, hit_aft, hit_bef;
    logic [LW:0]   top_end;

    always_comb begin
        fits    = r_valid && (CW'(r_len) >= i_size);
        lower   = r_base < i_pick_b;
        case (i_ctl.policy)
            FIT_BEST:  better = (r_len != i_pick_l) ? (r_len < i_pick_l) : lower;
            FIT_WORST: better = (r_len != i_pick_l) ? (r_len > i_pick_l) : lower;
            default:   better = lower;
        endcase
        take    = fits && (!i_pick_v || better);
        top_end = {1'b0, r_base} + {1'b0, r_len};
        hit_aft = r_valid && (r_base == i_fend);
        hit_bef = r_valid && !hit_aft && (top_end == {1'b0, i_fbase});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= i_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_pick_v <= i_pick_v || take;
            r_pick_i <= take ? ME : i_pick_i;
            r_pick_b <= take ? r_base : i_pick_b;
            r_pick_l <= take ? r_len : i_pick_l;
            r_bef_v  <= i_bef_v || hit_bef;
            r_bef_i  <= hit_bef ? ME : i_bef_i;
            r_aft_v  <= i_aft_v || hit_aft;
            r_aft_i  <= hit_aft ? ME : i_aft_i;
            r_aft_l  <= hit_aft ? r_len : i_aft_l;
            r_slot_v <= i_slot_v || !r_valid;
            r_slot_i <= (!i_slot_v && !r_valid) ? ME : i_slot_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= (IDX == 0);
            r_base  <= '0;
            r_len   <= (IDX == 0) ? LW'(HEAP_SIZE) : '0;
        end else begin
            case (i_ctl.op)
                HOP_CARVE: begin
                    if (i_idx_a == ME) begin
                        if (r_len == i_len) begin
                            r_valid <= 1'b0;
                            r_base  <= '0;
                            r_len   <= '0;
                        end else begin
                            r_base <= r_base + i_len;
                            r_len  <= r_len - i_len;
                        end
                    end
                end
                HOP_JOIN: begin
                    if (i_idx_a == ME) begin
                        r_len <= r_len + i_len;
                    end else if (i_idx_b == ME) begin
                        r_valid <= 1'b0;
                        r_base  <= '0;
                        r_len   <= '0;
                    end
                end
                HOP_GROW_DOWN: begin
                    if (i_idx_a == ME) begin
                        r_base <= i_base;
                        r_len  <= r_len + i_len;
                    end
                end
                HOP_GROW_UP: begin
                    if (i_idx_a == ME) begin
                        r_len <= r_len + i_len;
                    end
                end
                HOP_NEW: begin
                    if (i_idx_a == ME) begin
                        r_valid <= 1'b1;
                        r_base  <= i_base;
                        r_len   <= i_len;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_go     = r_go;
    assign o_pick_v = r_pick_v;
    assign o_pick_i = r_pick_i;
    assign o_pick_b = r_pick_b;
    assign o_pick_l = r_pick_l;
    assign o_bef_v  = r_bef_v;
    assign o_bef_i  = r_bef_i;
    assign o_aft_v  = r_aft_v;
    assign o_aft_i  = r_aft_i;
    assign o_aft_l  = r_aft_l;
    assign o_slot_v = r_slot_v;
    assign o_slot_i = r_slot_i;

endmodule

// ===== hw/rtl/shac_used_cell.sv =====
// ----------------------------------------------------------------------------
// shac_used_cell
// One entry of the allocated block table plus its stage of the block search.
// ----------------------------------------------------------------------------
module shac_used_cell import shac_pkg::*; #(
    parameter int LW  = 11,
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_used_op          i_op,
    input  logic [NAME_W-1:0] i_tag,
    input  logic [IW-1:0]     i_idx,
    input  logic [LW-1:0]     i_base,
    input  logic [LW-1:0]     i_len,
    input  logic              i_go,
    input  logic              i_slot_v,
    input  logic [IW-1:0]     i_slot_i,
    input  logic              i_m_v,
    input  logic [IW-1:0]     i_m_i,
    input  logic [LW-1:0]     i_m_b,
    input  logic [LW-1:0]     i_m_l,
    output logic              o_go,
    output logic              o_slot_v,
    output logic [IW-1:0]     o_slot_i,
    output logic              o_m_v,
    output logic [IW-1:0]     o_m_i,
    output logic [LW-1:0]     o_m_b,
    output logic [LW-1:0]     o_m_l
);

    localparam logic [IW-1:0] ME = IW'(IDX);

    logic              r_valid;
    logic [NAME_W-1:0] r_tag;
    logic [LW-1:0]     r_base;
    logic [LW-1:0]     r_len;
    logic              r_go, r_slot_v, r_m_v;
    logic [IW-1:0]     r_slot_i, r_m_i;
    logic [LW-1:0]     r_m_b, r_m_l;
    logic              take;

    // The lowest-addressed block with the wanted name wins.
    assign take = r_valid && (r_tag == i_tag) && (!i_m_v || (r_base < i_m_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_go <= i_go;
            if (i_idx == ME) begin
                if (i_op == UOP_SET) begin
                    r_valid <= 1'b1;
                end else if (i_op == UOP_CLEAR) begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == UOP_SET && i_idx == ME) begin
            r_tag  <= i_tag;
            r_base <= i_base;
            r_len  <= i_len;
        end
        if (i_go) begin
            r_slot_v <= i_slot_v || !r_valid;
            r_slot_i <= (!i_slot_v && !r_valid) ? ME : i_slot_i;
            r_m_v    <= i_m_v || take;
            r_m_i    <= take ? ME : i_m_i;
            r_m_b    <= take ? r_base : i_m_b;
            r_m_l    <= take ? r_len : i_m_l;
        end
    end

    assign o_go     = r_go;
    assign o_slot_v = r_slot_v;
    assign o_slot_i = r_slot_i;
    assign o_m_v    = r_m_v;
    assign o_m_i    = r_m_i;
    assign o_m_b    = r_m_b;
    assign o_m_l    = r_m_l;

endmodule

// ===== hw/rtl/segment_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// segment_heap_allocator
// Allocates and frees named contiguous blocks of a heap, keeping free holes
// merged.
//
//  channel  | dir | tdata / data (low bit up)                   | tuser
//  s (req)  | in  | block_name[7:0], block_size[18:8], pad       | req_type
//  m (res)  | out | status[2:0], base_address[12:3], block_length | -
//  cfg      | in  | fit_policy[1:0]                              | -
//
// From accept to result, a search wave runs once through the row of block
// cells, then once through the row of hole cells, one cell per cycle, and
// the tables update in the cycle the result is loaded. An allocate of size
// zero skips both searches. Reset is synchronous and takes effect at once,
// no clearing pass. A new request is taken while a result still waits; a
// stalled result holds the next one in its final cycle.
// ----------------------------------------------------------------------------
module segment_heap_allocator import shac_pkg::*; #(
    parameter int HEAP_SIZE  = HEAP_SIZE_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // block_name, block_size, zero pad
    input  logic        i_s_tuser,   // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // status, base_address, block_length
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    localparam int LW = $clog2(HEAP_SIZE + 1);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = (LW > SIZE_W) ? LW : SIZE_W;

    t_state            r_state, n_state;
    logic [1:0]        r_policy;
    logic              r_type, r_zero, r_ugo, r_hgo;
    logic [NAME_W-1:0] r_tag;
    logic [CW-1:0]     r_size;
    logic              r_out_v;
    t_status           r_out_st;
    logic [LW-1:0]     r_out_b, r_out_l;

    // Wave buses between neighboring cells; entry 0 is the chain's head.
    logic          w_ugo [0:MAX_BLOCKS];
    logic          w_usv [0:MAX_BLOCKS];
    logic [IW-1:0] w_usi [0:MAX_BLOCKS];
    logic          w_umv [0:MAX_BLOCKS];
    logic [IW-1:0] w_umi [0:MAX_BLOCKS];
    logic [LW-1:0] w_umb [0:MAX_BLOCKS];
    logic [LW-1:0] w_uml [0:MAX_BLOCKS];
    logic          w_hgo [0:MAX_BLOCKS];
    logic          w_hpv [0:MAX_BLOCKS];
    logic [IW-1:0] w_hpi [0:MAX_BLOCKS];
    logic [LW-1:0] w_hpb [0:MAX_BLOCKS];
    logic [LW-1:0] w_hpl [0:MAX_BLOCKS];
    logic          w_hbv [0:MAX_BLOCKS];
    logic [IW-1:0] w_hbi [0:MAX_BLOCKS];
    logic          w_hav [0:MAX_BLOCKS];
    logic [IW-1:0] w_hai [0:MAX_BLOCKS];
    logic [LW-1:0] w_hal [0:MAX_BLOCKS];
    logic          w_hsv [0:MAX_BLOCKS];
    logic [IW-1:0] w_hsi [0:MAX_BLOCKS];

    logic              s_acc, fire;
    t_hole_ctl         hole_ctl;
    logic [IW-1:0]     h_idx_a, h_idx_b, u_idx;
    logic [LW-1:0]     h_base, h_len, u_base, u_len, f_end;
    t_used_op          u_op;
    t_status           n_st;
    logic [LW-1:0]     n_b, n_l;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign fire        = (r_state == S_DONE) && (!r_out_v || i_m_tready);
    assign f_end       = w_umb[MAX_BLOCKS] + w_uml[MAX_BLOCKS];

    assign w_ugo[0] = r_ugo;
    assign w_usv[0] = 1'b0;
    assign w_usi[0] = '0;
    assign w_umv[0] = 1'b0;
    assign w_umi[0] = '0;
    assign w_umb[0] = '0;
    assign w_uml[0] = '0;
    assign w_hgo[0] = r_hgo;
    assign w_hpv[0] = 1'b0;
    assign w_hpi[0] = '0;
    assign w_hpb[0] = '0;
    assign w_hpl[0] = '0;
    assign w_hbv[0] = 1'b0;
    assign w_hbi[0] = '0;
    assign w_hav[0] = 1'b0;
    assign w_hai[0] = '0;
    assign w_hal[0] = '0;
    assign w_hsv[0] = 1'b0;
    assign w_hsi[0] = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_BLOCKS; k++) begin : g_cell
            shac_used_cell #(.LW(LW), .IW(IW), .IDX(k)) u_used (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_op(u_op), .i_tag(r_tag), .i_idx(u_idx),
                .i_base(u_base), .i_len(u_len),
                .i_go(w_ugo[k]), .i_slot_v(w_usv[k]), .i_slot_i(w_usi[k]),
                .i_m_v(w_umv[k]), .i_m_i(w_umi[k]), .i_m_b(w_umb[k]),
                .i_m_l(w_uml[k]),
                .o_go(w_ugo[k+1]), .o_slot_v(w_usv[k+1]), .o_slot_i(w_usi[k+1]),
                .o_m_v(w_umv[k+1]), .o_m_i(w_umi[k+1]), .o_m_b(w_umb[k+1]),
                .o_m_l(w_uml[k+1])
            );
            shac_hole_cell #(
                .LW(LW), .IW(IW), .CW(CW), .IDX(k), .HEAP_SIZE(HEAP_SIZE)
            ) u_hole (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_ctl(hole_ctl), .i_size(r_size),
                .i_fbase(w_umb[MAX_BLOCKS]), .i_fend(f_end),
                .i_idx_a(h_idx_a), .i_idx_b(h_idx_b),
                .i_base(h_base), .i_len(h_len),
                .i_go(w_hgo[k]),
                .i_pick_v(w_hpv[k]), .i_pick_i(w_hpi[k]),
                .i_pick_b(w_hpb[k]), .i_pick_l(w_hpl[k]),
                .i_bef_v(w_hbv[k]), .i_bef_i(w_hbi[k]),
                .i_aft_v(w_hav[k]), .i_aft_i(w_hai[k]), .i_aft_l(w_hal[k]),
                .i_slot_v(w_hsv[k]), .i_slot_i(w_hsi[k]),
                .o_go(w_hgo[k+1]),
                .o_pick_v(w_hpv[k+1]), .o_pick_i(w_hpi[k+1]),
                .o_pick_b(w_hpb[k+1]), .o_pick_l(w_hpl[k+1]),
                .o_bef_v(w_hbv[k+1]), .o_bef_i(w_hbi[k+1]),
                .o_aft_v(w_hav[k+1]), .o_aft_i(w_hai[k+1]), .o_aft_l(w_hal[k+1]),
                .o_slot_v(w_hsv[k+1]), .o_slot_i(w_hsi[k+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= '0;
            r_ugo    <= 1'b0;
            r_hgo    <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_policy <= i_cfg_data;
            end
            r_ugo <= s_acc && !(i_s_tuser == REQ_ALLOC && i_s_tdata[18:8] == '0);
            r_hgo <= (r_state == S_USCAN) && w_ugo[MAX_BLOCKS];
            if (fire) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_type <= i_s_tuser;
            r_tag  <= i_s_tdata[7:0];
            r_size <= CW'(i_s_tdata[18:8]);
            r_zero <= (i_s_tdata[18:8] == '0);
        end
        if (fire) begin
            r_out_st <= n_st;
            r_out_b  <= n_b;
            r_out_l  <= n_l;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = (i_s_tuser == REQ_ALLOC && i_s_tdata[18:8] == '0)
                              ? S_DONE : S_USCAN;
                end
            end
            S_USCAN: if (w_ugo[MAX_BLOCKS]) n_state = S_HSCAN;
            S_HSCAN: if (w_hgo[MAX_BLOCKS]) n_state = S_DONE;
            S_DONE:  if (fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Decision and table update, issued in the cycle the result is loaded.
    always_comb begin
        hole_ctl.policy = r_policy;
        hole_ctl.op     = HOP_NONE;
        h_idx_a = '0;
        h_idx_b = '0;
        h_base  = '0;
        h_len   = '0;
        u_op    = UOP_NONE;
        u_idx   = '0;
        u_base  = '0;
        u_len   = '0;
        n_st    = ST_OK;
        n_b     = '0;
        n_l     = '0;
        if (r_type == REQ_ALLOC) begin
            if (r_zero) begin
                n_st = ST_ZERO;
            end else if (!w_usv[MAX_BLOCKS]) begin
                n_st = ST_FULL;
            end else if (!w_hpv[MAX_BLOCKS]) begin
                n_st = ST_NOFIT;
            end else begin
                hole_ctl.op = HOP_CARVE;
                h_idx_a = w_hpi[MAX_BLOCKS];
                h_len   = LW'(r_size);
                u_op    = UOP_SET;
                u_idx   = w_usi[MAX_BLOCKS];
                u_base  = w_hpb[MAX_BLOCKS];
                u_len   = LW'(r_size);
                n_b     = w_hpb[MAX_BLOCKS];
                n_l     = LW'(r_size);
            end
        end else begin
            if (!w_umv[MAX_BLOCKS]) begin
                n_st = ST_NOTFOUND;
            end else if (!w_hbv[MAX_BLOCKS] && !w_hav[MAX_BLOCKS] &&
                         !w_hsv[MAX_BLOCKS]) begin
                n_st = ST_FULL;
            end else begin
                u_op  = UOP_CLEAR;
                u_idx = w_umi[MAX_BLOCKS];
                n_b   = w_umb[MAX_BLOCKS];
                n_l   = w_uml[MAX_BLOCKS];
                h_base = w_umb[MAX_BLOCKS];
                h_len  = w_uml[MAX_BLOCKS];
                if (w_hbv[MAX_BLOCKS] && w_hav[MAX_BLOCKS]) begin
                    hole_ctl.op = HOP_JOIN;
                    h_idx_a = w_hbi[MAX_BLOCKS];
                    h_idx_b = w_hai[MAX_BLOCKS];
                    h_len   = w_uml[MAX_BLOCKS] + w_hal[MAX_BLOCKS];
                end else if (w_hav[MAX_BLOCKS]) begin
                    hole_ctl.op = HOP_GROW_DOWN;
                    h_idx_a = w_hai[MAX_BLOCKS];
                end else if (w_hbv[MAX_BLOCKS]) begin
                    hole_ctl.op = HOP_GROW_UP;
                    h_idx_a = w_hbi[MAX_BLOCKS];
                end else begin
                    hole_ctl.op = HOP_NEW;
                    h_idx_a = w_hsi[MAX_BLOCKS];
                end
            end
        end
        if (!fire) begin
            hole_ctl.op = HOP_NONE;
            u_op        = UOP_NONE;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {LENGTH_W'(r_out_l), BASE_W'(r_out_b), r_out_st};

`ifndef SYNTH
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[2:0] != ST_OK) |-> (o_m_tdata[23:3] == '0))
        else $error("error result carries a nonzero base or length");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[2:0] == ST_OK) |-> (o_m_tdata[23:13] != '0))
        else $error("granted or released block has zero length");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!w_ugo[MAX_BLOCKS] && !w_hgo[MAX_BLOCKS] && !r_ugo && !r_hgo))
        else $error("search wave in flight while taking a request");
`endif

endmodule

// ===== tb/segment_heap_allocator_chk.sv =====
// ----------------------------------------------------------------------------
// segment_heap_allocator_chk
// Watches the request, result and configuration channels of the allocator.
// It keeps its own copy of the hole and block tables, predicts one result
// word per accepted request and compares every result word field by field.
// ----------------------------------------------------------------------------
module segment_heap_allocator_chk import shac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = MAX_BLOCKS_DEF;

    typedef struct packed {
        t_status             status;
        logic [BASE_W-1:0]   base;
        logic [LENGTH_W-1:0] length;
    } t_grant;

    logic [1:0]          policy;
    logic                hole_on   [NSLOT];
    logic [BASE_W-1:0]   hole_at   [NSLOT];
    logic [LENGTH_W-1:0] hole_len  [NSLOT];
    logic                blk_on    [NSLOT];
    logic [NAME_W-1:0]   blk_name  [NSLOT];
    logic [BASE_W-1:0]   blk_at    [NSLOT];
    logic [LENGTH_W-1:0] blk_len   [NSLOT];
    t_grant              grants_due[$];

    assign o_pending = grants_due.size();

    function automatic logic hole_wins(int c, int p);
        logic lower;
        lower = hole_at[c] < hole_at[p];
        if (policy == FIT_BEST && hole_len[c] != hole_len[p])
            return hole_len[c] < hole_len[p];
        if (policy == FIT_WORST && hole_len[c] != hole_len[p])
            return hole_len[c] > hole_len[p];
        return lower;
    endfunction

    task automatic grant_block(input logic [NAME_W-1:0] nm, input logic [SIZE_W-1:0] sz,
                               output t_grant g);
        int slot, pick;
        slot = -1;
        pick = -1;
        g = '{ST_OK, '0, '0};
        if (sz == 0) begin
            g.status = ST_ZERO;
            return;
        end
        for (int i = NSLOT - 1; i >= 0; i--)
            if (!blk_on[i]) slot = i;
        if (slot < 0) begin
            g.status = ST_FULL;
            return;
        end
        for (int i = 0; i < NSLOT; i++)
            if (hole_on[i] && hole_len[i] >= sz && (pick < 0 || hole_wins(i, pick)))
                pick = i;
        if (pick < 0) begin
            g.status = ST_NOFIT;
            return;
        end
        g.base   = hole_at[pick];
        g.length = sz;
        hole_at[pick]  = hole_at[pick] + sz;
        hole_len[pick] = hole_len[pick] - sz;
        if (hole_len[pick] == 0) begin
            hole_on[pick] = 1'b0;
            hole_at[pick] = '0;
        end
        blk_on[slot]   = 1'b1;
        blk_name[slot] = nm;
        blk_at[slot]   = g.base;
        blk_len[slot]  = sz;
    endtask

    task automatic release_block(input logic [NAME_W-1:0] nm, output t_grant g);
        int blk, below, above, slot;
        int lo, hi;
        blk = -1;
        below = -1;
        above = -1;
        slot = -1;
        g = '{ST_OK, '0, '0};
        for (int i = 0; i < NSLOT; i++)
            if (blk_on[i] && blk_name[i] == nm && (blk < 0 || blk_at[i] < blk_at[blk]))
                blk = i;
        if (blk < 0) begin
            g.status = ST_NOTFOUND;
            return;
        end
        lo = blk_at[blk];
        hi = lo + blk_len[blk];
        for (int i = 0; i < NSLOT; i++) begin
            if (!hole_on[i]) continue;
            if (int'(hole_at[i]) == hi) above = i;
            else if (int'(hole_at[i]) + int'(hole_len[i]) == lo) below = i;
        end
        if (below >= 0 && above >= 0) begin
            hole_len[below] = hole_len[below] + blk_len[blk] + hole_len[above];
            hole_on[above]  = 1'b0;
            hole_at[above]  = '0;
            hole_len[above] = '0;
        end else if (above >= 0) begin
            hole_at[above]  = blk_at[blk];
            hole_len[above] = hole_len[above] + blk_len[blk];
        end else if (below >= 0) begin
            hole_len[below] = hole_len[below] + blk_len[blk];
        end else begin
            for (int i = NSLOT - 1; i >= 0; i--)
                if (!hole_on[i]) slot = i;
            if (slot < 0) begin
                // No hole entry left for an isolated range: the block stays put.
                g.status = ST_FULL;
                return;
            end
            hole_on[slot]  = 1'b1;
            hole_at[slot]  = blk_at[blk];
            hole_len[slot] = blk_len[blk];
        end
        blk_on[blk] = 1'b0;
        g.base   = blk_at[blk];
        g.length = blk_len[blk];
    endtask

    always @(posedge i_clk) begin
        t_grant g, seen;
        if (!i_rst_n) begin
            policy = '0;
            for (int i = 0; i < NSLOT; i++) begin
                hole_on[i]  = 1'b0;
                hole_at[i]  = '0;
                hole_len[i] = '0;
                blk_on[i]   = 1'b0;
            end
            hole_on[0]  = 1'b1;
            hole_len[0] = LENGTH_W'(HEAP_SIZE_DEF);
            grants_due.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                policy = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == REQ_ALLOC)
                    grant_block(i_s_tdata[7:0], i_s_tdata[18:8], g);
                else
                    release_block(i_s_tdata[7:0], g);
                grants_due.push_back(g);
            end
            if (i_m_tvalid && i_m_tready) begin
                seen = '{t_status'(i_m_tdata[2:0]), i_m_tdata[12:3], i_m_tdata[23:13]};
                if (grants_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: result word with nothing outstanding: %h",
                                 $realtime, i_m_tdata);
                end else begin
                    g = grants_due.pop_front();
                    if (seen.status != g.status || seen.base != g.base ||
                        seen.length != g.length) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: status/base/length expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, g.status, g.base, g.length,
                                     seen.status, seen.base, seen.length);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/segment_heap_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// segment_heap_allocator_tb
// Drives allocate and free requests into the heap allocator under all fit
// policies and with random idling on both stream sides; the checker predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module segment_heap_allocator_tb import shac_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2 * MAX_BLOCKS_DEF + 20;
    localparam logic REQ_FREE     = ~REQ_ALLOC;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [23:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_data = '0;
    logic        o_s_tready, o_m_tvalid, o_cfg_ready;
    logic [23:0] o_m_tdata;
    int          errors, pending;
    int          tx_idle = 0, rx_idle = 0, quiet = 0;

    always #6 i_clk = ~i_clk;

    segment_heap_allocator dut (.*);

    segment_heap_allocator_chk chk (
        .i_clk, .i_rst_n, .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= rx_idle);
    end

    // Watchdog: any accepted word on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(input logic req, input logic [7:0] nm,
                                input logic [10:0] sz);
        while ($urandom_range(99) < tx_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {5'b0, sz, nm};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Pause the request stream until every result is back, then set the policy.
    task automatic set_policy(input logic [1:0] pol);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= pol;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        logic [7:0]  nm;
        logic [10:0] sz;
        int          pick;
        nm = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 70)      sz = 11'($urandom_range(24, 1));
        else if (pick < 90) sz = 11'($urandom_range(200, 25));
        else if (pick < 95) sz = '0;
        else                sz = 11'($urandom_range(1024, 201));
        // Allocates slightly outnumber frees so the block table fills now and then.
        send_request(($urandom_range(99) < 58) ? REQ_ALLOC : REQ_FREE, nm, sz);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Whole heap, oversize, merges, size zero, unknown name, duplicate names.
        send_request(REQ_ALLOC, 8'h00, 11'd1024);
        send_request(REQ_ALLOC, 8'hFF, 11'd1);
        send_request(REQ_FREE,  8'h00, 11'd0);
        send_request(REQ_ALLOC, 8'hFF, 11'd0);
        send_request(REQ_FREE,  8'h4D, 11'h7FF);
        send_request(REQ_ALLOC, 8'hAA, 11'd1);
        send_request(REQ_ALLOC, 8'h55, 11'd1023);
        send_request(REQ_FREE,  8'hAA, 11'd0);
        send_request(REQ_FREE,  8'h55, 11'd0);
        send_request(REQ_ALLOC, 8'h03, 11'd5);
        send_request(REQ_ALLOC, 8'h03, 11'd7);
        send_request(REQ_ALLOC, 8'h04, 11'd9);
        send_request(REQ_FREE,  8'h03, 11'd0);
        send_request(REQ_ALLOC, 8'h05, 11'd2);
        send_request(REQ_FREE,  8'h04, 11'd0);
        send_request(REQ_FREE,  8'h03, 11'd0);
        send_request(REQ_FREE,  8'h05, 11'd0);
        send_request(REQ_FREE,  8'h03, 11'd0);

        for (int ph = 0; ph < 4; ph++) begin
            set_policy(2'(ph + 1));
            tx_idle = (ph == 0) ? 32 : (ph == 1) ? 47 : 0;
            rx_idle = (ph == 0) ? 47 : (ph == 1) ? 32 : 0;
            repeat (350) random_request();
        end
        i_s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/shac_pkg.sv
hw/rtl/shac_hole_cell.sv
hw/rtl/shac_used_cell.sv
hw/rtl/segment_heap_allocator.sv
tb/segment_heap_allocator_chk.sv
tb/segment_heap_allocator_tb.sv
